// ----- rtl/icss_pkg.sv -----
// Shared types and constants for the interval coverage sweep block.
// Depends on nothing; used by interval_coverage_sweep_core and its testbench.
package icss_pkg;

    localparam int DEPTH_W = 6;
    localparam int MEAN_W  = 33;
    localparam int FIELD_W = 32;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic                      op;
        logic signed [FIELD_W-1:0] left_pos;
        logic signed [FIELD_W-1:0] right_pos;
    } in_item_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] point_pos;
        logic [DEPTH_W-1:0]        depth_before;
        logic [MEAN_W-1:0]         mean_before;
        logic [DEPTH_W-1:0]        depth_after;
        logic [MEAN_W-1:0]         mean_after;
        logic [DEPTH_W-1:0]        peak_depth;
        logic                      dropped;
        logic                      last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RET_CHK,
        ST_RET_RD,
        ST_OPEN,
        ST_INS_CHK,
        ST_INS_RD,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage

// ----- rtl/interval_coverage_sweep_core.sv -----
// Sweep-line interval coverage: active intervals kept in a circular memory sorted by right end.
// Depends on icss_pkg and icss_div.
//
// Usage: intervals enter on the s_ channel sorted by left end (op add), or a flush
// transaction retires everything still active. Each retire or open produces one
// result on the m_ channel with position, depth and mean length before and after,
// and the running peak depth; the final result of an input carries last.
// An add that finds the store full after its retires yields one result with dropped.
// One input is worked on at a time; s_ready is high only while the sequencer is idle.
// Each result costs a head read or an insertion walk (a read and a write per entry
// moved for an open) plus, unless the store is left empty or the add is dropped, one
// division of POS_BITS+6 quotient bits, which holds the sequencer until it is done.
// Results sit in an output register; while the receiver stalls, the sequencer holds
// before loading the next result and no state is lost.
// Reset (aresetn low, synchronous) empties the store and clears the peak; the memory
// contents are not cleared since only entries below the active count are read.
module interval_coverage_sweep_core #(
    parameter int MAX_ACTIVE = 63,
    parameter int POS_BITS   = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  icss_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output icss_pkg::out_item_t  m_data
);
    localparam int DW        = icss_pkg::DEPTH_W;
    localparam int MW        = icss_pkg::MEAN_W;
    localparam int LEN_W     = POS_BITS + 1;
    localparam int SUM_W     = POS_BITS + 6;
    localparam int ENT_W     = POS_BITS + LEN_W;
    localparam int ADDR_W    = $clog2(MAX_ACTIVE + 1);
    localparam int MEM_DEPTH = 1 << ADDR_W;

    icss_pkg::state_t state_reg, state_next;

    logic                       op_reg, op_next;
    logic signed [POS_BITS-1:0] left_reg, left_next;
    logic signed [POS_BITS-1:0] right_reg, right_next;
    logic [LEN_W-1:0]           len_reg, len_next;
    logic [DW-1:0]              count_reg, count_next;
    logic [ADDR_W-1:0]          head_reg, head_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [DW-1:0]              peak_reg, peak_next;
    logic [MW-1:0]              cur_mean_reg, cur_mean_next;
    logic [DW-1:0]              k_reg, k_next;

    icss_pkg::out_item_t        res_reg, res_next;
    logic                       usediv_reg, usediv_next;
    logic                       retire_reg, retire_next;

    icss_pkg::out_item_t        m_data_reg, m_data_next;
    logic                       m_valid_reg, m_valid_next;

    logic [ENT_W-1:0]  mem [MEM_DEPTH];
    logic [ENT_W-1:0]  mem_q_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              we;
    logic [ADDR_W-1:0] wa;
    logic [ENT_W-1:0]  wd;

    logic               div_start;
    logic [SUM_W-1:0]   div_num;
    logic [DW-1:0]      div_den;
    logic [SUM_W-1:0]   div_q;
    logic               div_done;
    logic [SUM_W+MW-1:0] div_q_wide;

    logic signed [POS_BITS-1:0] in_left, in_right, clamp_right;
    logic signed [POS_BITS:0]   len_diff;
    logic signed [POS_BITS-1:0] ent_right;
    logic [LEN_W-1:0]           ent_len;
    logic [SUM_W-1:0]           ent_len_ext, len_ext;
    logic                       out_free;

    assign in_left     = s_data.left_pos[POS_BITS-1:0];
    assign in_right    = s_data.right_pos[POS_BITS-1:0];
    assign clamp_right = (in_right < in_left) ? in_left : in_right;
    assign len_diff    = {clamp_right[POS_BITS-1], clamp_right} - {in_left[POS_BITS-1], in_left};

    assign ent_right   = mem_q_reg[ENT_W-1 -: POS_BITS];
    assign ent_len     = mem_q_reg[LEN_W-1:0];
    assign ent_len_ext = {5'b0, ent_len};
    assign len_ext     = {5'b0, len_reg};
    assign out_free    = !m_valid_reg || m_ready;
    assign div_q_wide  = {{MW{1'b0}}, div_q};

    assign s_ready = (state_reg == icss_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    icss_div #(
        .NUM_W(SUM_W),
        .DEN_W(DW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .quotient (div_q),
        .done     (div_done)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            icss_pkg::ST_IDLE: begin
                if (s_valid) state_next = icss_pkg::ST_RET_CHK;
            end
            icss_pkg::ST_RET_CHK: begin
                if (count_reg != '0)              state_next = icss_pkg::ST_RET_RD;
                else if (op_reg == icss_pkg::OP_FLUSH) state_next = icss_pkg::ST_IDLE;
                else                              state_next = icss_pkg::ST_OPEN;
            end
            icss_pkg::ST_RET_RD: begin
                if (op_reg == icss_pkg::OP_FLUSH || ent_right <= left_reg)
                    state_next = icss_pkg::ST_DIV;
                else
                    state_next = icss_pkg::ST_OPEN;
            end
            icss_pkg::ST_OPEN: begin
                if (count_reg >= DW'(MAX_ACTIVE)) state_next = icss_pkg::ST_DIV;
                else                             state_next = icss_pkg::ST_INS_CHK;
            end
            icss_pkg::ST_INS_CHK: begin
                if (k_reg == '0) state_next = icss_pkg::ST_DIV;
                else             state_next = icss_pkg::ST_INS_RD;
            end
            icss_pkg::ST_INS_RD: begin
                if (ent_right > right_reg) state_next = icss_pkg::ST_INS_CHK;
                else                       state_next = icss_pkg::ST_DIV;
            end
            icss_pkg::ST_DIV: begin
                if (!usediv_reg || div_done) state_next = icss_pkg::ST_EMIT;
            end
            icss_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = retire_reg ? icss_pkg::ST_RET_CHK : icss_pkg::ST_IDLE;
                end
            end
            default: state_next = icss_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        op_next       = op_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        len_next      = len_reg;
        count_next    = count_reg;
        head_next     = head_reg;
        sum_next      = sum_reg;
        peak_next     = peak_reg;
        cur_mean_next = cur_mean_reg;
        k_next        = k_reg;
        res_next      = res_reg;
        usediv_next   = usediv_reg;
        retire_next   = retire_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        rd_addr       = head_reg;
        we            = 1'b0;
        wa            = head_reg;
        wd            = {right_reg, len_reg};
        div_start     = 1'b0;
        div_num       = sum_reg;
        div_den       = count_reg;

        case (state_reg)
            icss_pkg::ST_IDLE: begin
                if (s_valid) begin
                    op_next    = s_data.op;
                    left_next  = in_left;
                    right_next = clamp_right;
                    len_next   = LEN_W'(len_diff) + LEN_W'(1);
                end
            end
            icss_pkg::ST_RET_CHK: begin
                rd_addr = head_reg;
            end
            icss_pkg::ST_RET_RD: begin
                if (op_reg == icss_pkg::OP_FLUSH || ent_right <= left_reg) begin
                    count_next            = count_reg - 1'b1;
                    sum_next              = sum_reg - ent_len_ext;
                    head_next             = head_reg + 1'b1;
                    res_next.point_pos    = icss_pkg::FIELD_W'(ent_right);
                    res_next.depth_before = count_reg;
                    res_next.mean_before  = cur_mean_reg;
                    res_next.depth_after  = count_next;
                    res_next.mean_after   = '0;
                    res_next.peak_depth   = peak_reg;
                    res_next.dropped      = 1'b0;
                    res_next.last         = (op_reg == icss_pkg::OP_FLUSH) && (count_next == '0);
                    retire_next           = 1'b1;
                    usediv_next           = (count_next != '0);
                    div_start             = (count_next != '0);
                    div_num               = sum_next;
                    div_den               = count_next;
                end
            end
            icss_pkg::ST_OPEN: begin
                k_next = count_reg;
                if (count_reg >= DW'(MAX_ACTIVE)) begin
                    res_next.point_pos    = icss_pkg::FIELD_W'(left_reg);
                    res_next.depth_before = count_reg;
                    res_next.mean_before  = cur_mean_reg;
                    res_next.depth_after  = count_reg;
                    res_next.mean_after   = cur_mean_reg;
                    res_next.peak_depth   = peak_reg;
                    res_next.dropped      = 1'b1;
                    res_next.last         = 1'b1;
                    retire_next           = 1'b0;
                    usediv_next           = 1'b0;
                end
            end
            icss_pkg::ST_INS_CHK, icss_pkg::ST_INS_RD: begin
                rd_addr = head_reg + ADDR_W'(k_reg - 1'b1);
                if (state_reg == icss_pkg::ST_INS_RD && ent_right > right_reg) begin
                    // Entry has a later right end: move it up one slot.
                    we     = 1'b1;
                    wa     = head_reg + ADDR_W'(k_reg);
                    wd     = mem_q_reg;
                    k_next = k_reg - 1'b1;
                end else if (state_reg == icss_pkg::ST_INS_RD || k_reg == '0) begin
                    we                    = 1'b1;
                    wa                    = head_reg + ADDR_W'(k_reg);
                    wd                    = {right_reg, len_reg};
                    count_next            = count_reg + 1'b1;
                    sum_next              = sum_reg + len_ext;
                    peak_next             = (count_next > peak_reg) ? count_next : peak_reg;
                    res_next.point_pos    = icss_pkg::FIELD_W'(left_reg);
                    res_next.depth_before = count_reg;
                    res_next.mean_before  = cur_mean_reg;
                    res_next.depth_after  = count_next;
                    res_next.mean_after   = '0;
                    res_next.peak_depth   = peak_next;
                    res_next.dropped      = 1'b0;
                    res_next.last         = 1'b1;
                    retire_next           = 1'b0;
                    usediv_next           = 1'b1;
                    div_start             = 1'b1;
                    div_num               = sum_next;
                    div_den               = count_next;
                end
            end
            icss_pkg::ST_DIV: begin
                if (usediv_reg && div_done) begin
                    res_next.mean_after = div_q_wide[MW-1:0];
                end
            end
            icss_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_data_next   = res_reg;
                    m_valid_next  = 1'b1;
                    cur_mean_next = res_reg.mean_after;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= icss_pkg::ST_IDLE;
            count_reg    <= '0;
            head_reg     <= '0;
            sum_reg      <= '0;
            peak_reg     <= '0;
            cur_mean_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            head_reg     <= head_next;
            sum_reg      <= sum_next;
            peak_reg     <= peak_next;
            cur_mean_reg <= cur_mean_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        len_reg    <= len_next;
        k_reg      <= k_next;
        res_reg    <= res_next;
        usediv_reg <= usediv_next;
        retire_reg <= retire_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        mem_q_reg <= mem[rd_addr];
    end

    // The active count never exceeds the store capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DW'(MAX_ACTIVE))
        else $error("active count above capacity");

    // A stalled result is not overwritten.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("pending result changed under stall");

    // A refused add is always the final result of its transaction and leaves depth unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.dropped |-> m_data.last && m_data.depth_after == m_data.depth_before)
        else $error("dropped result malformed");

    // Every other result moves the depth by exactly one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.dropped |->
            (m_data.depth_after == m_data.depth_before + 1'b1) ||
            (m_data.depth_after + 1'b1 == m_data.depth_before))
        else $error("depth step is not one");

endmodule

// ----- rtl/icss_div.sv -----
// Restoring divider, one quotient bit per cycle, for the mean active length.
// Depends on nothing; instantiated by interval_coverage_sweep_core.
module icss_div #(
    parameter int NUM_W = 38,
    parameter int DEN_W = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic [NUM_W-1:0] quotient,
    output logic             done
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CW-1:0]    cnt_reg;
    logic             done_reg;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign ge      = shifted >= {1'b0, den_reg};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CW'(NUM_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end else if (cnt_reg != '0) begin
            rem_reg <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ----- test/tb_interval_coverage_sweep_core.sv -----
// Self-checking testbench for interval_coverage_sweep_core: directed table, capacity fill, then
// random adds and flushes, random stalls on both channels. Depends on icss_pkg and the core RTL.
module tb_interval_coverage_sweep_core;

    localparam int CAP       = 63;
    localparam int LIMIT     = 2000000;
    localparam int N_RANDOM  = 80;
    localparam int QUIET_LEN = 30;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    icss_pkg::in_item_t   s_data;
    logic                 m_valid;
    logic                 m_ready;
    icss_pkg::out_item_t  m_data;

    interval_coverage_sweep_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Shadow of the block state.
    longint          open_right [CAP];
    logic [32:0]     open_len   [CAP];
    int              open_cnt;
    logic [37:0]     len_total;
    int              peak_seen;

    icss_pkg::out_item_t pending_points[$];
    int              errors;
    int              cycles;
    bit              idle_en;
    bit              hold_req;

    typedef struct {
        logic                op;
        int                  left_v;
        int                  right_v;
        bit                  typed;
        icss_pkg::out_item_t want;
    } row_t;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [32:0] mean_len(logic [37:0] s, int d);
        return (d == 0) ? 33'd0 : 33'(s / d);
    endfunction

    function automatic icss_pkg::out_item_t make_point(longint pos, int d0, logic [37:0] s0,
                                                       int d1, logic [37:0] s1, logic drop);
        icss_pkg::out_item_t p;
        p.point_pos    = pos[31:0];
        p.depth_before = d0[5:0];
        p.mean_before  = mean_len(s0, d0);
        p.depth_after  = d1[5:0];
        p.mean_after   = mean_len(s1, d1);
        p.peak_depth   = peak_seen[5:0];
        p.dropped      = drop;
        p.last         = 1'b0;
        return p;
    endfunction

    // Applies one input transaction to the shadow state; the change points go to pts.
    task automatic sweep_step(input icss_pkg::in_item_t it, output icss_pkg::out_item_t pts[$]);
        longint      l;
        longint      r;
        logic [37:0] s0;
        int          d0;
        int          i;
        pts = {};
        l = longint'(it.left_pos);
        r = longint'(it.right_pos);
        if (r < l) r = l;
        while (open_cnt > 0 && (it.op == icss_pkg::OP_FLUSH || open_right[0] <= l)) begin
            s0 = len_total;
            d0 = open_cnt;
            len_total = len_total - 38'(open_len[0]);
            pts.push_back(make_point(open_right[0], d0, s0, d0 - 1, len_total, 1'b0));
            for (i = 0; i < open_cnt - 1; i++) begin
                open_right[i] = open_right[i+1];
                open_len[i]   = open_len[i+1];
            end
            open_cnt--;
        end
        if (it.op == icss_pkg::OP_ADD) begin
            if (open_cnt >= CAP) begin
                pts.push_back(make_point(l, open_cnt, len_total, open_cnt, len_total, 1'b1));
            end else begin
                s0 = len_total;
                d0 = open_cnt;
                i  = 0;
                while (i < open_cnt && open_right[i] <= r) i++;
                for (int j = open_cnt; j > i; j--) begin
                    open_right[j] = open_right[j-1];
                    open_len[j]   = open_len[j-1];
                end
                open_right[i] = r;
                open_len[i]   = 33'(r - l + 1);
                open_cnt++;
                len_total = len_total + 38'(open_len[i]);
                if (open_cnt > peak_seen) peak_seen = open_cnt;
                pts.push_back(make_point(l, d0, s0, open_cnt, len_total, 1'b0));
            end
        end
        if (pts.size() > 0) pts[pts.size()-1].last = 1'b1;
    endtask

    task automatic report(input string msg);
        $display("mismatch @%0d: %s", cycles, msg);
        errors++;
    endtask

    // Offers one transaction and records what it should produce once accepted.
    task automatic offer(input icss_pkg::in_item_t it, input bit typed,
                         input icss_pkg::out_item_t want);
        icss_pkg::out_item_t pts[$];
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sweep_step(it, pts);
        if (typed) pending_points.push_back(want);
        else foreach (pts[k]) pending_points.push_back(pts[k]);
    endtask

    function automatic icss_pkg::in_item_t mk(logic op, int l, int r);
        icss_pkg::in_item_t it;
        it.op        = op;
        it.left_pos  = l;
        it.right_pos = r;
        return it;
    endfunction

    function automatic icss_pkg::out_item_t pt(int pos, int d0, longint m0, int d1, longint m1,
                                               int pk);
        icss_pkg::out_item_t p;
        p.point_pos    = pos;
        p.depth_before = d0[5:0];
        p.mean_before  = m0[32:0];
        p.depth_after  = d1[5:0];
        p.mean_after   = m1[32:0];
        p.peak_depth   = pk[5:0];
        p.dropped      = 1'b0;
        p.last         = 1'b1;
        return p;
    endfunction

    // Result side: random stalls, plus one long hold-off to back the block up.
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (700) @(posedge aclk);
                hold_req = 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_points.size() == 0) begin
                report($sformatf("unexpected result pos=%0d", $signed(m_data.point_pos)));
            end else begin
                icss_pkg::out_item_t w;
                w = pending_points.pop_front();
                if (m_data.point_pos !== w.point_pos)
                    report($sformatf("point_pos %0d, want %0d",
                                     $signed(m_data.point_pos), $signed(w.point_pos)));
                if (m_data.depth_before !== w.depth_before)
                    report($sformatf("depth_before %0d, want %0d",
                                     m_data.depth_before, w.depth_before));
                if (m_data.mean_before !== w.mean_before)
                    report($sformatf("mean_before %0d, want %0d",
                                     m_data.mean_before, w.mean_before));
                if (m_data.depth_after !== w.depth_after)
                    report($sformatf("depth_after %0d, want %0d",
                                     m_data.depth_after, w.depth_after));
                if (m_data.mean_after !== w.mean_after)
                    report($sformatf("mean_after %0d, want %0d",
                                     m_data.mean_after, w.mean_after));
                if (m_data.peak_depth !== w.peak_depth)
                    report($sformatf("peak_depth %0d, want %0d",
                                     m_data.peak_depth, w.peak_depth));
                if (m_data.dropped !== w.dropped)
                    report($sformatf("dropped %0b, want %0b", m_data.dropped, w.dropped));
                if (m_data.last !== w.last)
                    report($sformatf("last %0b, want %0b", m_data.last, w.last));
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("** interval_coverage_sweep_core: FAILED **");
            $finish;
        end
    end

    initial begin
        row_t                dir_rows[$];
        icss_pkg::out_item_t none;
        longint              cur_left;
        int                  l;
        int                  r;
        int                  base;
        icss_pkg::in_item_t  it;

        none      = '0;
        cycles    = 0;
        errors    = 0;
        idle_en   = 1'b1;
        hold_req  = 1'b0;
        open_cnt  = 0;
        len_total = '0;
        peak_seen = 0;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty start, extreme positions, reversed interval, empty flush.
        dir_rows = '{
            '{icss_pkg::OP_ADD,   0, 9, 1'b1, pt(0, 0, 0, 1, 10, 1)},
            '{icss_pkg::OP_FLUSH, 0, 0, 1'b1, pt(9, 1, 10, 0, 0, 1)},
            '{icss_pkg::OP_FLUSH, -1, -1, 1'b0, none},
            '{icss_pkg::OP_ADD, 32'sh8000_0000, 32'sh7fff_ffff, 1'b1,
                pt(32'sh8000_0000, 0, 0, 1, 64'h1_0000_0000, 1)},
            '{icss_pkg::OP_ADD, -100, -200, 1'b0, none},
            '{icss_pkg::OP_ADD, -100, -100, 1'b0, none},
            '{icss_pkg::OP_ADD, -50, 20, 1'b0, none},
            '{icss_pkg::OP_ADD, -50, 10, 1'b0, none},
            '{icss_pkg::OP_ADD, 10, 30, 1'b0, none},
            '{icss_pkg::OP_ADD, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0, none},
            '{icss_pkg::OP_FLUSH, 32'sh5555_5555, 32'shaaaa_aaaa, 1'b0, none},
            '{icss_pkg::OP_ADD, 32'shffff_ffff, 32'sh0000_0000, 1'b0, none},
            '{icss_pkg::OP_ADD, 32'shffff_ffff, 32'shffff_ffff, 1'b0, none},
            '{icss_pkg::OP_FLUSH, 0, 0, 1'b0, none}
        };
        foreach (dir_rows[k])
            offer(mk(dir_rows[k].op, dir_rows[k].left_v, dir_rows[k].right_v),
                  dir_rows[k].typed, dir_rows[k].want);

        // Fill the store with one shared left end; the extra add is refused.
        base = $urandom_range(0, 1000);
        for (int k = 0; k <= CAP; k++)
            offer(mk(icss_pkg::OP_ADD, base, base + $urandom_range(100, 1000)), 1'b0, none);
        offer(mk(icss_pkg::OP_FLUSH, 0, 0), 1'b0, none);

        hold_req = 1'b1;
        cur_left = $urandom_range(0, 2000000) - 1000000;
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == N_RANDOM - QUIET_LEN) idle_en = 1'b0;
            if ($urandom_range(0, 11) == 0) begin
                it = mk(icss_pkg::OP_FLUSH, $urandom, $urandom);
            end else if ($urandom_range(0, 9) == 0) begin
                it = mk(icss_pkg::OP_ADD, $urandom, $urandom);
            end else begin
                cur_left = cur_left + $urandom_range(0, 8);
                l = int'(cur_left);
                if ($urandom_range(0, 9) == 0) r = l - $urandom_range(1, 5);
                else if ($urandom_range(0, 19) == 0) r = l + $urandom_range(0, 1000000);
                else r = l + $urandom_range(0, 40);
                it = mk(icss_pkg::OP_ADD, l, r);
            end
            offer(it, 1'b0, none);
        end
        s_valid <= 1'b0;

        while (pending_points.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (errors == 0) begin
            $display("** interval_coverage_sweep_core: PASSED **");
        end else begin
            $display("** interval_coverage_sweep_core: FAILED **");
        end
        $finish;
    end

endmodule
